/* design/r2a_pkg.sv */
// Shared types and constants for the radix integer to ASCII converter.
// No dependencies; compile first.
package r2a_pkg;

	// Fixed field widths
	localparam int VALUE_W = 32;
	localparam int CHAR_W  = 7;
	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;

	// Digit stack and count
	localparam int STACK_DEPTH = 32;
	localparam int STACK_AW    = 5;
	localparam int COUNT_W     = 6;

	// Quotient bits retired per cycle by the division step
	localparam int BITS_PER_STEP = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'h61;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BAD,
		ST_DIV,
		ST_EMIT
	} r2a_state_t;

	// Digit value 0..35 to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + {1'b0, d};
		end else begin
			c = CHAR_LOWER_A + {1'b0, d - DEC_DIGITS};
		end
		return c;
	endfunction

endpackage

/* design/r2a_if.sv */
// Valid/ready channel interfaces for the converter: input number and output character.
// Depends on r2a_pkg.
interface r2a_value_if import r2a_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface r2a_char_if import r2a_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last;
	logic              bad_radix;

	modport source (output valid, output digit_char, output last, output bad_radix, input ready);
	modport sink   (input valid, input digit_char, input last, input bad_radix, output ready);
endinterface

/* design/radix_integer_to_ascii.sv */
// Radix integer to ASCII converter: top level, FSM, division step and digit stack.
// Depends on r2a_pkg and the interfaces in r2a_if.sv.
//
// Usage:
//   din  carries one unsigned number per word; dout carries one ASCII character
//   per word, most significant digit first, with last on the final character.
//   cfg_we/cfg_wdata write the radix register (2..36, reset 10); write it only
//   while the block is idle. A radix outside 2..36 gives one word with
//   digit_char 0, last 1 and bad_radix 1.
// Timing:
//   The shared division step retires 4 quotient bits a cycle; the digits of a
//   number are all divided out first, least significant first, then popped one
//   character per cycle, most significant first, while the receiver is ready.
//   din.ready is high only while idle; one number is converted at a time.
// Reset and stall:
//   arst_n clears the sequencer, the output valid and the radix (to 10).
//   A stalled receiver holds the output register; popping waits for it. The
//   next number is taken as soon as the last character sits in the register.
module radix_integer_to_ascii import r2a_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	r2a_value_if.sink          din,
	r2a_char_if.source         dout,
	input  logic               cfg_we,
	input  logic [RADIX_W-1:0] cfg_wdata
);

	// Quotient width, padded to a whole number of division steps
	localparam int QW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int QP    = ((QW + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
	localparam int STEPS = QP / BITS_PER_STEP;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	r2a_state_t state_q, state_n;

	logic [RADIX_W-1:0]  radix_q;
	logic [QP-1:0]       quot_q, quot_n;
	logic [DIGIT_W-1:0]  rem_q, rem_n;
	logic [SW-1:0]       step_q;
	logic [COUNT_W-1:0]  count_q;
	logic [DIGIT_W-1:0]  stack_q [STACK_DEPTH];

	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;
	logic                out_bad_q;

	logic                radix_ok;
	logic                accept;
	logic                out_free;
	logic                last_step;
	logic                push;
	logic                out_load;
	logic [STACK_AW-1:0] pop_idx;
	logic [DIGIT_W-1:0]  pop_digit;

	assign radix_ok  = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
	assign accept    = din.valid && din.ready;
	assign out_free  = !out_valid_q || dout.ready;
	assign last_step = (step_q == SW'(STEPS - 1));
	assign pop_idx   = STACK_AW'(count_q - COUNT_W'(1));
	assign pop_digit = stack_q[pop_idx];

	// Radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// Shared division step: four restoring steps on the narrow remainder
	always_comb begin
		logic [DIGIT_W:0] t;
		quot_n = quot_q;
		rem_n  = rem_q;
		t      = '0;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t      = {rem_n, quot_n[QP-1]};
			quot_n = {quot_n[QP-2:0], 1'b0};
			if (t >= {1'b0, radix_q}) begin
				t         = t - {1'b0, radix_q};
				quot_n[0] = 1'b1;
			end
			rem_n = t[DIGIT_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (din.valid) begin
					state_n = radix_ok ? ST_DIV : ST_BAD;
				end
			end
			ST_BAD: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (last_step && ((quot_n == '0) || (count_q == COUNT_W'(STACK_DEPTH - 1)))) begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && (count_q == COUNT_W'(1))) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		din.ready = 1'b0;
		push      = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: din.ready = 1'b1;
			ST_BAD:  out_load  = out_free;
			ST_DIV:  push      = last_step;
			ST_EMIT: out_load  = out_free;
			default: din.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Quotient, remainder, step and digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q  <= '0;
			rem_q   <= '0;
			step_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			quot_q  <= QP'(din.value[QW-1:0]);
			rem_q   <= '0;
			step_q  <= '0;
			count_q <= '0;
		end else if (state_q == ST_DIV) begin
			quot_q <= quot_n;
			if (push) begin
				rem_q   <= '0;
				step_q  <= '0;
				count_q <= count_q + COUNT_W'(1);
			end else begin
				rem_q  <= rem_n;
				step_q <= step_q + SW'(1);
			end
		end else if (out_load && (state_q == ST_EMIT)) begin
			count_q <= count_q - COUNT_W'(1);
		end
	end

	// Digit stack, written before it is read
	always_ff @(posedge clk) begin
		if (push) begin
			stack_q[count_q[STACK_AW-1:0]] <= rem_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_BAD) begin
				out_char_q <= '0;
				out_last_q <= 1'b1;
				out_bad_q  <= 1'b1;
			end else begin
				out_char_q <= digit_to_char(pop_digit);
				out_last_q <= (count_q == COUNT_W'(1));
				out_bad_q  <= 1'b0;
			end
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.digit_char = out_char_q;
	assign dout.last       = out_last_q;
	assign dout.bad_radix  = out_bad_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(STACK_DEPTH))
		else $error("digit count beyond stack depth");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (count_q != '0))
		else $error("popping an empty digit stack");

	a_good_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && radix_ok) |=> (state_q == ST_DIV))
		else $error("valid radix did not start division");

	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.bad_radix) |-> (dout.last && (dout.digit_char == '0)))
		else $error("bad radix word malformed");

endmodule
